// ===== src/s2d_pkg.sv =====
// s2d_pkg: widths, register codes, stage indices and the restoring divide step
// shared by the space-to-depth address core and its checker
// no dependencies

package s2d_pkg;

   // word field widths
   localparam int COL_BITS      = 10;
   localparam int ROW_BITS      = 10;
   localparam int CHAN_BITS     = 11;
   localparam int IMAGE_BITS    = 4;
   localparam int DATA_BITS     = 32;
   localparam int ADDR_BITS     = 35;

   // register widths
   localparam int DIM_BITS      = 11;
   localparam int CHANNELS_BITS = 12;
   localparam int BATCH_BITS    = 5;
   localparam int STRIDE_BITS   = 4;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS = 12;

   // register limits
   localparam logic [DIM_BITS-1:0]      MAX_DIM      = 11'd1024;
   localparam logic [CHANNELS_BITS-1:0] MAX_CHANNELS = 12'd2048;
   localparam logic [BATCH_BITS-1:0]    MAX_BATCH    = 5'd16;
   localparam logic [STRIDE_BITS-1:0]   MAX_STRIDE   = 4'd8;

   // register reset values
   localparam logic [DIM_BITS-1:0]      WIDTH_RESET    = 11'd1;
   localparam logic [DIM_BITS-1:0]      HEIGHT_RESET   = 11'd1;
   localparam logic [CHANNELS_BITS-1:0] CHANNELS_RESET = 12'd4;
   localparam logic [BATCH_BITS-1:0]    BATCH_RESET    = 5'd1;
   localparam logic [STRIDE_BITS-1:0]   STRIDE_RESET   = 4'd2;
   localparam logic                     FORWARD_RESET  = 1'b1;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_IN_WIDTH     = 3'd0,
      CSR_IN_HEIGHT    = 3'd1,
      CSR_IN_CHANNELS  = 3'd2,
      CSR_BATCH_COUNT  = 3'd3,
      CSR_BLOCK_STRIDE = 3'd4,
      CSR_FORWARD_MODE = 3'd5
   } csr_index_type;

   // divider: 12 quotient bits, two per pipeline stage
   localparam int QUO_BITS       = 12;
   localparam int BITS_PER_STAGE = 2;
   localparam int DIV_STAGES     = QUO_BITS / BITS_PER_STAGE;

   // pipeline stage indices
   localparam int STG_IN     = 0;
   localparam int STG_DIV    = 1;
   localparam int STG_MIX    = STG_DIV + DIV_STAGES;
   localparam int STG_MUL    = STG_MIX + 1;
   localparam int STG_SUM    = STG_MUL + 1;
   localparam int STG_OUT    = STG_SUM + 1;
   localparam int NUM_STAGES = STG_OUT + 1;

   // config-time divider sequence
   localparam logic [3:0] CFG_LOAD      = 4'd0;
   localparam logic [3:0] CFG_LAST_STEP = 4'd12;
   localparam logic [3:0] CFG_DONE      = 4'd13;

   typedef struct packed {
      logic [COL_BITS-1:0]   col;
      logic [ROW_BITS-1:0]   row;
      logic [CHAN_BITS-1:0]  chan;
      logic [IMAGE_BITS-1:0] image;
      logic [DATA_BITS-1:0]  data;
      logic                  bad;
   } item_type;

   typedef struct packed {
      item_type              it;
      logic [QUO_BITS-1:0]   num;
      logic [QUO_BITS-1:0]   r1;
      logic [QUO_BITS-1:0]   q1;
      logic [QUO_BITS-1:0]   r2;
      logic [QUO_BITS-1:0]   q2;
   } div_type;

   // one restoring step: returns {quotient bit, new remainder}
   function automatic logic [QUO_BITS:0] div_step(input logic [QUO_BITS-1:0] rem,
                                                  input logic nbit,
                                                  input logic [QUO_BITS-1:0] den);
      logic [QUO_BITS:0] shifted;
      logic [QUO_BITS:0] diff;
      shifted = {rem, nbit};
      diff    = shifted - {1'b0, den};
      if (shifted >= {1'b0, den}) begin
         div_step = {1'b1, diff[QUO_BITS-1:0]};
      end else begin
         div_step = {1'b0, shifted[QUO_BITS-1:0]};
      end
   endfunction

endpackage

// ===== src/space_to_depth_reorg_address_core.sv =====
// space_to_depth_reorg_address_core: reorg (space-to-depth) address generator
// depends on s2d_pkg
//
// usage: one req word carries an element's col/row/chan/image and its value;
// one rsp word returns the read and write flat addresses, the value and an
// error flag. both channels are valid/ready; csr is a plain write port
// (csr_write, csr_index, csr_data) taken at once.
// a new word can be taken every cycle, unless a stall on rsp has filled every
// stage or the channel-count divide runs. the pipeline is eleven register
// stages: input, six stages of a two-bit-per-stage restoring divider
// (chan by the reduced channel count and by that count times stride), then
// three multiply/add stages and the output register.
// the reduced channel count is found by a bit-serial divider; req_ready is
// low while it runs, after reset and after each csr write.
// reset clears all valid bits and loads the register reset values.
// a stall on rsp holds the output word; bubbles inside the pipe still close
// up, and req_ready drops only when a full pipe stalls or the divide runs.

module space_to_depth_reorg_address_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [s2d_pkg::COL_BITS-1:0]         req_col,
   input  logic [s2d_pkg::ROW_BITS-1:0]         req_row,
   input  logic [s2d_pkg::CHAN_BITS-1:0]        req_chan,
   input  logic [s2d_pkg::IMAGE_BITS-1:0]       req_image,
   input  logic [s2d_pkg::DATA_BITS-1:0]        req_data_in,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [s2d_pkg::ADDR_BITS-1:0]        rsp_source_address,
   output logic [s2d_pkg::ADDR_BITS-1:0]        rsp_dest_address,
   output logic [s2d_pkg::DATA_BITS-1:0]        rsp_data_out,
   output logic                                 rsp_bad_config,
   input  logic                                 csr_write,
   input  logic [s2d_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [s2d_pkg::CSR_DATA_BITS-1:0]    csr_data
);

   // configuration registers
   logic [s2d_pkg::DIM_BITS-1:0]      w_ff;
   logic [s2d_pkg::DIM_BITS-1:0]      h_ff;
   logic [s2d_pkg::CHANNELS_BITS-1:0] c_ff;
   logic [s2d_pkg::BATCH_BITS-1:0]    n_ff;
   logic [s2d_pkg::STRIDE_BITS-1:0]   s_ff;
   logic                              fwd_ff;

   // derived values
   logic [14:0] tw_ff;
   logic [14:0] th_ff;
   logic [14:0] tw_in;
   logic [14:0] th_in;
   logic [s2d_pkg::QUO_BITS-1:0] tc_ff;
   logic [s2d_pkg::QUO_BITS-1:0] ts_ff;
   logic [15:0] ts_prod;
   logic        cfg_bad;

   // bit-serial divider for the reduced channel count
   logic                         busy_ff;
   logic [3:0]                   cnt_ff;
   logic [s2d_pkg::QUO_BITS-1:0] cnum_ff;
   logic [s2d_pkg::QUO_BITS-1:0] crem_ff;
   logic [7:0]                   s_sq;
   logic [s2d_pkg::QUO_BITS:0]   cstep;

   // pipeline control
   logic [s2d_pkg::NUM_STAGES-1:0] v_ff;
   logic [s2d_pkg::NUM_STAGES-1:0] adv;
   logic                           req_take;

   // input stage
   s2d_pkg::item_type s0_ff;
   s2d_pkg::item_type s0_in;

   // divider stages
   s2d_pkg::div_type div_ff  [s2d_pkg::DIV_STAGES];
   s2d_pkg::div_type div_src [s2d_pkg::DIV_STAGES];
   s2d_pkg::div_type div_in  [s2d_pkg::DIV_STAGES];

   // mix stage
   logic [14:0] sq2_prod;
   logic [10:0] kms_full;
   logic [15:0] ti_prod;
   logic [15:0] ci_prod;
   logic [13:0] cs_prod;
   logic [13:0] rs_prod;
   logic [3:0]  s7_kms_ff;
   logic [15:0] s7_cti_ff;
   logic [13:0] s7_cs_ff;
   logic [13:0] s7_rs_ff;
   logic [10:0] s7_q2_ff;
   logic [15:0] s7_ci_ff;
   logic [s2d_pkg::ROW_BITS-1:0]  s7_row_ff;
   logic [s2d_pkg::COL_BITS-1:0]  s7_col_ff;
   logic [s2d_pkg::DATA_BITS-1:0] s7_data_ff;
   logic                          s7_bad_ff;

   // multiply stage
   logic [30:0] t1_prod;
   logic [26:0] hr_prod;
   logic [13:0] s8_w2_ff;
   logic [13:0] s8_h2_ff;
   logic [30:0] s8_t1_ff;
   logic [26:0] s8_hr_ff;
   logic [s2d_pkg::COL_BITS-1:0]  s8_col_ff;
   logic [s2d_pkg::DATA_BITS-1:0] s8_data_ff;
   logic                          s8_bad_ff;

   // sum stage
   logic [37:0] bot_prod;
   logic [13:0] s9_w2_ff;
   logic [31:0] s9_t2_ff;
   logic [s2d_pkg::ADDR_BITS-1:0] s9_bot_ff;
   logic [s2d_pkg::DATA_BITS-1:0] s9_data_ff;
   logic                          s9_bad_ff;

   // output stage
   logic [46:0] top_prod;
   logic [s2d_pkg::ADDR_BITS-1:0] top_addr;
   logic [s2d_pkg::ADDR_BITS-1:0] out_src_ff;
   logic [s2d_pkg::ADDR_BITS-1:0] out_dst_ff;
   logic [s2d_pkg::DATA_BITS-1:0] out_data_ff;
   logic                          out_bad_ff;

   // ---------------------------------------------------------------------
   // configuration

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff   <= s2d_pkg::WIDTH_RESET;
         h_ff   <= s2d_pkg::HEIGHT_RESET;
         c_ff   <= s2d_pkg::CHANNELS_RESET;
         n_ff   <= s2d_pkg::BATCH_RESET;
         s_ff   <= s2d_pkg::STRIDE_RESET;
         fwd_ff <= s2d_pkg::FORWARD_RESET;
      end else if (csr_write) begin
         case (csr_index)
            s2d_pkg::CSR_IN_WIDTH:     w_ff   <= csr_data[s2d_pkg::DIM_BITS-1:0];
            s2d_pkg::CSR_IN_HEIGHT:    h_ff   <= csr_data[s2d_pkg::DIM_BITS-1:0];
            s2d_pkg::CSR_IN_CHANNELS:  c_ff   <= csr_data[s2d_pkg::CHANNELS_BITS-1:0];
            s2d_pkg::CSR_BATCH_COUNT:  n_ff   <= csr_data[s2d_pkg::BATCH_BITS-1:0];
            s2d_pkg::CSR_BLOCK_STRIDE: s_ff   <= csr_data[s2d_pkg::STRIDE_BITS-1:0];
            s2d_pkg::CSR_FORWARD_MODE: fwd_ff <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   // reset or any write restarts the channel-count divide
   always_ff @(posedge clock) begin
      if (reset || csr_write) begin
         busy_ff <= 1'b1;
         cnt_ff  <= s2d_pkg::CFG_LOAD;
      end else if (busy_ff) begin
         if (cnt_ff == s2d_pkg::CFG_DONE) begin
            busy_ff <= 1'b0;
         end else begin
            cnt_ff <= 4'(cnt_ff + 4'd1);
         end
      end
   end

   assign s_sq  = s_ff * s_ff;
   assign cstep = s2d_pkg::div_step(crem_ff, cnum_ff[s2d_pkg::QUO_BITS-1], {4'b0, s_sq});

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         if (cnt_ff == s2d_pkg::CFG_LOAD) begin
            cnum_ff <= c_ff;
            crem_ff <= '0;
            tc_ff   <= '0;
         end else if (cnt_ff <= s2d_pkg::CFG_LAST_STEP) begin
            cnum_ff <= {cnum_ff[s2d_pkg::QUO_BITS-2:0], 1'b0};
            crem_ff <= cstep[s2d_pkg::QUO_BITS-1:0];
            tc_ff   <= {tc_ff[s2d_pkg::QUO_BITS-2:0], cstep[s2d_pkg::QUO_BITS]};
         end
      end
   end

   assign tw_in   = w_ff * s_ff;
   assign th_in   = h_ff * s_ff;
   assign ts_prod = tc_ff * s_ff;

   always_ff @(posedge clock) begin
      tw_ff <= tw_in;
      th_ff <= th_in;
      ts_ff <= ts_prod[s2d_pkg::QUO_BITS-1:0];
   end

   assign cfg_bad = (s_ff == '0) || (tc_ff == '0) ||
                    (w_ff > s2d_pkg::MAX_DIM) || (h_ff > s2d_pkg::MAX_DIM) ||
                    (c_ff > s2d_pkg::MAX_CHANNELS) || (n_ff > s2d_pkg::MAX_BATCH) ||
                    (s_ff > s2d_pkg::MAX_STRIDE);

   // ---------------------------------------------------------------------
   // pipeline handshake: a stage loads when it is empty or its word moves on

   always_comb begin
      adv[s2d_pkg::STG_OUT] = !v_ff[s2d_pkg::STG_OUT] || rsp_ready;
      for (int i = s2d_pkg::STG_OUT - 1; i >= 0; i--) begin
         adv[i] = !v_ff[i] || adv[i+1];
      end
   end

   assign req_ready = adv[s2d_pkg::STG_IN] && !busy_ff;
   assign req_take  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (adv[s2d_pkg::STG_IN]) begin
            v_ff[s2d_pkg::STG_IN] <= req_take;
         end
         for (int i = 1; i < s2d_pkg::NUM_STAGES; i++) begin
            if (adv[i]) begin
               v_ff[i] <= v_ff[i-1];
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // input stage with range check

   always_comb begin
      s0_in.col   = req_col;
      s0_in.row   = req_row;
      s0_in.chan  = req_chan;
      s0_in.image = req_image;
      s0_in.data  = req_data_in;
      s0_in.bad   = cfg_bad ||
                    ({1'b0, req_col} >= w_ff) || ({1'b0, req_row} >= h_ff) ||
                    ({1'b0, req_chan} >= c_ff) || ({1'b0, req_image} >= n_ff);
   end

   always_ff @(posedge clock) begin
      if (adv[s2d_pkg::STG_IN]) begin
         s0_ff <= s0_in;
      end
   end

   // ---------------------------------------------------------------------
   // divider stages: chan / tc and chan / (tc * s) side by side

   always_comb begin
      s2d_pkg::div_type cur;
      logic [s2d_pkg::QUO_BITS:0] st1;
      logic [s2d_pkg::QUO_BITS:0] st2;
      div_src[0].it  = s0_ff;
      div_src[0].num = {1'b0, s0_ff.chan};
      div_src[0].r1  = '0;
      div_src[0].q1  = '0;
      div_src[0].r2  = '0;
      div_src[0].q2  = '0;
      for (int g = 1; g < s2d_pkg::DIV_STAGES; g++) begin
         div_src[g] = div_ff[g-1];
      end
      for (int g = 0; g < s2d_pkg::DIV_STAGES; g++) begin
         cur = div_src[g];
         for (int b = 0; b < s2d_pkg::BITS_PER_STAGE; b++) begin
            st1 = s2d_pkg::div_step(cur.r1, cur.num[s2d_pkg::QUO_BITS-1], tc_ff);
            st2 = s2d_pkg::div_step(cur.r2, cur.num[s2d_pkg::QUO_BITS-1], ts_ff);
            cur.r1  = st1[s2d_pkg::QUO_BITS-1:0];
            cur.q1  = {cur.q1[s2d_pkg::QUO_BITS-2:0], st1[s2d_pkg::QUO_BITS]};
            cur.r2  = st2[s2d_pkg::QUO_BITS-1:0];
            cur.q2  = {cur.q2[s2d_pkg::QUO_BITS-2:0], st2[s2d_pkg::QUO_BITS]};
            cur.num = {cur.num[s2d_pkg::QUO_BITS-2:0], 1'b0};
         end
         div_in[g] = cur;
      end
   end

   always_ff @(posedge clock) begin
      for (int g = 0; g < s2d_pkg::DIV_STAGES; g++) begin
         if (adv[s2d_pkg::STG_DIV + g]) begin
            div_ff[g] <= div_in[g];
         end
      end
   end

   // ---------------------------------------------------------------------
   // mix stage: k % s, c2 + tc*image, col*s, row*s, chan + C*image

   assign sq2_prod = s_ff * div_ff[s2d_pkg::DIV_STAGES-1].q2[10:0];
   assign kms_full = div_ff[s2d_pkg::DIV_STAGES-1].q1[10:0] - sq2_prod[10:0];
   assign ti_prod  = tc_ff * div_ff[s2d_pkg::DIV_STAGES-1].it.image;
   assign ci_prod  = c_ff * div_ff[s2d_pkg::DIV_STAGES-1].it.image;
   assign cs_prod  = div_ff[s2d_pkg::DIV_STAGES-1].it.col * s_ff;
   assign rs_prod  = div_ff[s2d_pkg::DIV_STAGES-1].it.row * s_ff;

   always_ff @(posedge clock) begin
      if (adv[s2d_pkg::STG_MIX]) begin
         s7_kms_ff  <= kms_full[3:0];
         s7_cti_ff  <= {4'b0, div_ff[s2d_pkg::DIV_STAGES-1].r1} + ti_prod;
         s7_cs_ff   <= cs_prod;
         s7_rs_ff   <= rs_prod;
         s7_q2_ff   <= div_ff[s2d_pkg::DIV_STAGES-1].q2[10:0];
         s7_ci_ff   <= ci_prod + {5'b0, div_ff[s2d_pkg::DIV_STAGES-1].it.chan};
         s7_row_ff  <= div_ff[s2d_pkg::DIV_STAGES-1].it.row;
         s7_col_ff  <= div_ff[s2d_pkg::DIV_STAGES-1].it.col;
         s7_data_ff <= div_ff[s2d_pkg::DIV_STAGES-1].it.data;
         s7_bad_ff  <= div_ff[s2d_pkg::DIV_STAGES-1].it.bad;
      end
   end

   // ---------------------------------------------------------------------
   // multiply stage

   assign t1_prod = th_ff * s7_cti_ff;
   assign hr_prod = h_ff * s7_ci_ff;

   always_ff @(posedge clock) begin
      if (adv[s2d_pkg::STG_MUL]) begin
         s8_w2_ff   <= s7_cs_ff + {10'b0, s7_kms_ff};
         s8_h2_ff   <= s7_rs_ff + {3'b0, s7_q2_ff};
         s8_t1_ff   <= t1_prod;
         s8_hr_ff   <= hr_prod + {17'b0, s7_row_ff};
         s8_col_ff  <= s7_col_ff;
         s8_data_ff <= s7_data_ff;
         s8_bad_ff  <= s7_bad_ff;
      end
   end

   // ---------------------------------------------------------------------
   // sum stage: input-layout address complete here

   assign bot_prod = w_ff * s8_hr_ff;

   always_ff @(posedge clock) begin
      if (adv[s2d_pkg::STG_SUM]) begin
         s9_w2_ff   <= s8_w2_ff;
         s9_t2_ff   <= {1'b0, s8_t1_ff} + {18'b0, s8_h2_ff};
         s9_bot_ff  <= bot_prod[s2d_pkg::ADDR_BITS-1:0] + {25'b0, s8_col_ff};
         s9_data_ff <= s8_data_ff;
         s9_bad_ff  <= s8_bad_ff;
      end
   end

   // ---------------------------------------------------------------------
   // output stage: reorg address, role swap, zero on error

   assign top_prod = tw_ff * s9_t2_ff;
   assign top_addr = top_prod[s2d_pkg::ADDR_BITS-1:0] + {21'b0, s9_w2_ff};

   always_ff @(posedge clock) begin
      if (adv[s2d_pkg::STG_OUT]) begin
         out_data_ff <= s9_data_ff;
         out_bad_ff  <= s9_bad_ff;
         if (s9_bad_ff) begin
            out_src_ff <= '0;
            out_dst_ff <= '0;
         end else if (fwd_ff) begin
            out_src_ff <= s9_bot_ff;
            out_dst_ff <= top_addr;
         end else begin
            out_src_ff <= top_addr;
            out_dst_ff <= s9_bot_ff;
         end
      end
   end

   assign rsp_valid          = v_ff[s2d_pkg::STG_OUT];
   assign rsp_source_address = out_src_ff;
   assign rsp_dest_address   = out_dst_ff;
   assign rsp_data_out       = out_data_ff;
   assign rsp_bad_config     = out_bad_ff;

endmodule

// ===== src/s2d_checker.sv =====
// s2d_checker: port-level assertions for the space-to-depth address core
// depends on s2d_pkg; bound to space_to_depth_reorg_address_core below

module s2d_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_ready,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic [s2d_pkg::ADDR_BITS-1:0]        rsp_source_address,
   input logic [s2d_pkg::ADDR_BITS-1:0]        rsp_dest_address,
   input logic [s2d_pkg::DATA_BITS-1:0]        rsp_data_out,
   input logic                                 rsp_bad_config,
   input logic                                 csr_write
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_source_address) &&
         $stable(rsp_dest_address) && $stable(rsp_data_out) && $stable(rsp_bad_config))
      else $error("rsp word changed while stalled");

   // a flagged word carries no addresses
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_config |-> rsp_source_address == '0 && rsp_dest_address == '0)
      else $error("flagged word with nonzero address");

   // the channel-count divide blocks input after a register write
   a_csr_block: assert property (@(posedge clock) disable iff (reset)
      csr_write |=> !req_ready)
      else $error("req_ready high right after a register write");

   // likewise after reset, with no rsp word valid
   a_reset_block: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("block ready or valid right after reset");

endmodule

bind space_to_depth_reorg_address_core s2d_checker u_s2d_checker (.*);

// ===== tb/tb_space_to_depth_reorg_address_core.sv =====
// tb_space_to_depth_reorg_address_core: self-checking bench for the reorg address core
// drives req words and csr writes, predicts every rsp word and compares it field by field
// depends on s2d_pkg and space_to_depth_reorg_address_core

module tb_space_to_depth_reorg_address_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [s2d_pkg::CSR_INDEX_BITS-1:0] CSR_UNMAPPED_LO = 3'd6;
   localparam logic [s2d_pkg::CSR_INDEX_BITS-1:0] CSR_UNMAPPED_HI = 3'd7;

   typedef struct {
      logic [s2d_pkg::ADDR_BITS-1:0] source_address;
      logic [s2d_pkg::ADDR_BITS-1:0] dest_address;
      logic [s2d_pkg::DATA_BITS-1:0] data_out;
      logic                          bad_config;
   } reorg_word_type;

   class reorg_scoreboard;
      logic [s2d_pkg::DIM_BITS-1:0]      width_reg;
      logic [s2d_pkg::DIM_BITS-1:0]      height_reg;
      logic [s2d_pkg::CHANNELS_BITS-1:0] channels_reg;
      logic [s2d_pkg::BATCH_BITS-1:0]    batch_reg;
      logic [s2d_pkg::STRIDE_BITS-1:0]   stride_reg;
      logic                              forward_reg;
      reorg_word_type                    awaited[$];
      int unsigned                       mismatch_count;

      function new();
         width_reg      = s2d_pkg::WIDTH_RESET;
         height_reg     = s2d_pkg::HEIGHT_RESET;
         channels_reg   = s2d_pkg::CHANNELS_RESET;
         batch_reg      = s2d_pkg::BATCH_RESET;
         stride_reg     = s2d_pkg::STRIDE_RESET;
         forward_reg    = s2d_pkg::FORWARD_RESET;
         mismatch_count = 0;
      endfunction

      task report(string what);
         mismatch_count++;
         $display("mismatch at %0t ns: %s", $time, what);
      endtask

      function void write_register(logic [s2d_pkg::CSR_INDEX_BITS-1:0] idx,
                                   logic [s2d_pkg::CSR_DATA_BITS-1:0] value);
         case (idx)
            s2d_pkg::CSR_IN_WIDTH:     width_reg    = value[s2d_pkg::DIM_BITS-1:0];
            s2d_pkg::CSR_IN_HEIGHT:    height_reg   = value[s2d_pkg::DIM_BITS-1:0];
            s2d_pkg::CSR_IN_CHANNELS:  channels_reg = value[s2d_pkg::CHANNELS_BITS-1:0];
            s2d_pkg::CSR_BATCH_COUNT:  batch_reg    = value[s2d_pkg::BATCH_BITS-1:0];
            s2d_pkg::CSR_BLOCK_STRIDE: stride_reg   = value[s2d_pkg::STRIDE_BITS-1:0];
            s2d_pkg::CSR_FORWARD_MODE: forward_reg  = value[0];
            default: ;
         endcase
      endfunction

      function reorg_word_type reorg_addresses(longint unsigned col, row, chan, image,
                                               logic [s2d_pkg::DATA_BITS-1:0] data);
         reorg_word_type  word;
         longint unsigned w, h, c, n, s, tc, k, bottom, top;
         w  = width_reg;
         h  = height_reg;
         c  = channels_reg;
         n  = batch_reg;
         s  = stride_reg;
         tc = (s == 0) ? 0 : c / (s * s);
         word.data_out       = data;
         word.source_address = '0;
         word.dest_address   = '0;
         // zero stride gives tc of zero as well
         word.bad_config = (tc == 0) || col >= w || row >= h || chan >= c || image >= n
                           || w > s2d_pkg::MAX_DIM || h > s2d_pkg::MAX_DIM
                           || c > s2d_pkg::MAX_CHANNELS || n > s2d_pkg::MAX_BATCH
                           || s > s2d_pkg::MAX_STRIDE;
         if (!word.bad_config) begin
            k      = chan / tc;
            bottom = col + w * (row + h * (chan + c * image));
            top    = col * s + k % s
                     + w * s * (row * s + k / s + h * s * (chan % tc + tc * image));
            if (forward_reg) begin
               word.source_address = s2d_pkg::ADDR_BITS'(bottom);
               word.dest_address   = s2d_pkg::ADDR_BITS'(top);
            end else begin
               word.source_address = s2d_pkg::ADDR_BITS'(top);
               word.dest_address   = s2d_pkg::ADDR_BITS'(bottom);
            end
         end
         return word;
      endfunction

      function void note_request(logic [s2d_pkg::COL_BITS-1:0] col,
                                 logic [s2d_pkg::ROW_BITS-1:0] row,
                                 logic [s2d_pkg::CHAN_BITS-1:0] chan,
                                 logic [s2d_pkg::IMAGE_BITS-1:0] image,
                                 logic [s2d_pkg::DATA_BITS-1:0] data);
         awaited.push_back(reorg_addresses(col, row, chan, image, data));
      endfunction

      task check_response(reorg_word_type got);
         reorg_word_type want;
         if (awaited.size() == 0) begin
            report("rsp word with no req word outstanding");
            return;
         end
         want = awaited.pop_front();
         if (got.source_address !== want.source_address)
            report($sformatf("source_address %0h, expected %0h",
                             got.source_address, want.source_address));
         if (got.dest_address !== want.dest_address)
            report($sformatf("dest_address %0h, expected %0h",
                             got.dest_address, want.dest_address));
         if (got.data_out !== want.data_out)
            report($sformatf("data_out %0h, expected %0h", got.data_out, want.data_out));
         if (got.bad_config !== want.bad_config)
            report($sformatf("bad_config %b, expected %b", got.bad_config, want.bad_config));
      endtask
   endclass

   logic                               clock       = 1'b0;
   logic                               reset       = 1'b1;
   logic                               req_valid   = 1'b0;
   logic                               req_ready;
   logic [s2d_pkg::COL_BITS-1:0]       req_col     = '0;
   logic [s2d_pkg::ROW_BITS-1:0]       req_row     = '0;
   logic [s2d_pkg::CHAN_BITS-1:0]      req_chan    = '0;
   logic [s2d_pkg::IMAGE_BITS-1:0]     req_image   = '0;
   logic [s2d_pkg::DATA_BITS-1:0]      req_data_in = '0;
   logic                               rsp_valid;
   logic                               rsp_ready   = 1'b0;
   logic [s2d_pkg::ADDR_BITS-1:0]      rsp_source_address;
   logic [s2d_pkg::ADDR_BITS-1:0]      rsp_dest_address;
   logic [s2d_pkg::DATA_BITS-1:0]      rsp_data_out;
   logic                               rsp_bad_config;
   logic                               csr_write   = 1'b0;
   logic [s2d_pkg::CSR_INDEX_BITS-1:0] csr_index   = '0;
   logic [s2d_pkg::CSR_DATA_BITS-1:0]  csr_data    = '0;

   reorg_scoreboard addr_board;
   int unsigned     stall_left = 0;
   bit              send_quiet = 1'b0;
   bit              recv_quiet = 1'b0;
   int unsigned     random_sent = 0;
   int unsigned     burst;
   bit              clean;

   space_to_depth_reorg_address_core i_dut (.*);

   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         addr_board.note_request(req_col, req_row, req_chan, req_image, req_data_in);
      if (!reset && rsp_valid && rsp_ready)
         addr_board.check_response('{rsp_source_address, rsp_dest_address,
                                      rsp_data_out, rsp_bad_config});
   end

   // mostly short gaps, now and then a long one
   function automatic int unsigned gap_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 12);
      return $urandom_range(30, 80);
   endfunction

   always @(negedge clock) begin
      if (stall_left != 0) begin
         rsp_ready = 1'b0;
         stall_left--;
      end else if (!recv_quiet && $urandom_range(0, 99) < 20) begin
         rsp_ready  = 1'b0;
         stall_left = gap_len() - 1;
      end else begin
         rsp_ready = 1'b1;
      end
   end

   // called at a falling edge; valid stays up afterwards until the next word or a drain
   task automatic send_word(int unsigned col, row, chan, image,
                            logic [s2d_pkg::DATA_BITS-1:0] data);
      int unsigned gap;
      gap = (send_quiet || $urandom_range(0, 99) < 55) ? 0 : gap_len();
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   = 1'b1;
      req_col     = s2d_pkg::COL_BITS'(col);
      req_row     = s2d_pkg::ROW_BITS'(row);
      req_chan    = s2d_pkg::CHAN_BITS'(chan);
      req_image   = s2d_pkg::IMAGE_BITS'(image);
      req_data_in = data;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (addr_board.awaited.size() != 0) @(negedge clock);
   endtask

   task automatic write_csr(logic [s2d_pkg::CSR_INDEX_BITS-1:0] idx, int unsigned value,
                            int unsigned bits);
      logic [s2d_pkg::CSR_DATA_BITS-1:0] word;
      word = s2d_pkg::CSR_DATA_BITS'(value);
      // junk above a narrow register must be dropped by the core
      if (bits < s2d_pkg::CSR_DATA_BITS && $urandom_range(0, 3) == 0)
         word = word | (s2d_pkg::CSR_DATA_BITS'($urandom) << bits);
      csr_write = 1'b1;
      csr_index = idx;
      csr_data  = word;
      @(posedge clock);
      addr_board.write_register(idx, word);
      @(negedge clock);
   endtask

   task automatic set_config(int unsigned w, h, c, n, s, fwd, bit stray);
      write_csr(s2d_pkg::CSR_IN_WIDTH, w, s2d_pkg::DIM_BITS);
      write_csr(s2d_pkg::CSR_IN_HEIGHT, h, s2d_pkg::DIM_BITS);
      write_csr(s2d_pkg::CSR_IN_CHANNELS, c, s2d_pkg::CHANNELS_BITS);
      write_csr(s2d_pkg::CSR_BATCH_COUNT, n, s2d_pkg::BATCH_BITS);
      write_csr(s2d_pkg::CSR_BLOCK_STRIDE, s, s2d_pkg::STRIDE_BITS);
      write_csr(s2d_pkg::CSR_FORWARD_MODE, fwd, 1);
      if (stray)
         write_csr($urandom_range(0, 1) ? CSR_UNMAPPED_LO : CSR_UNMAPPED_HI, $urandom, 0);
      csr_write = 1'b0;
   endtask

   function automatic int unsigned pick_dim();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 75) return $urandom_range(1, 16);
      if (r < 90) return $urandom_range(17, 1023);
      if (r < 94) return s2d_pkg::MAX_DIM;
      if (r < 98) return $urandom_range(1025, 2047);
      return 0;
   endfunction

   task automatic random_config();
      int unsigned s, max_tc, tc, c, n, r;
      r = $urandom_range(0, 99);
      if (r < 92) s = $urandom_range(1, 8);
      else if (r < 95) s = 0;
      else s = $urandom_range(9, 15);
      max_tc = (s == 0 || s > 8) ? 64 : 2048 / (s * s);
      tc = ($urandom_range(0, 3) == 0) ? $urandom_range(1, max_tc)
                                       : $urandom_range(1, max_tc < 8 ? max_tc : 8);
      c = (s == 0) ? tc : tc * s * s;
      // ragged channel counts, and now and then anything at all
      if ($urandom_range(0, 99) < 20) c = c + $urandom_range(0, s * s);
      if ($urandom_range(0, 99) < 5) c = $urandom_range(0, 4095);
      r = $urandom_range(0, 99);
      if (r < 88) n = $urandom_range(1, 16);
      else if (r < 93) n = 0;
      else n = $urandom_range(17, 31);
      set_config(pick_dim(), pick_dim(), c, n, s, $urandom_range(0, 1),
                 $urandom_range(0, 9) == 0);
   endtask

   // clean words stay inside the tensor; the rest sit on the edge or anywhere
   function automatic int unsigned pick_coord(int unsigned limit, int unsigned bits, bit inside_map);
      int unsigned span, r;
      span = 1 << bits;
      if (inside_map && limit != 0) return $urandom_range(0, (limit < span ? limit : span) - 1);
      r = $urandom_range(0, 3);
      if (r == 0 && limit != 0) return (limit - 1) % span;
      if (r == 1) return limit % span;
      return $urandom_range(0, span - 1);
   endfunction

   initial begin
      addr_board = new();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset shape: 1x1 map, four channels, stride two, so one reduced channel
      send_word(0, 0, 0, 0, 32'h0000_0000);
      send_word(0, 0, 1, 0, 32'hffff_ffff);
      send_word(0, 0, 2, 0, $urandom);
      send_word(0, 0, 3, 0, $urandom);
      // each coordinate at its field maximum, all out of range here
      send_word(1023, 0, 0, 0, $urandom);
      send_word(0, 1023, 0, 0, $urandom);
      send_word(0, 0, 2047, 0, $urandom);
      send_word(0, 0, 0, 15, $urandom);
      drain();

      // largest legal tensor, both directions
      set_config(s2d_pkg::MAX_DIM, s2d_pkg::MAX_DIM, s2d_pkg::MAX_CHANNELS,
                 s2d_pkg::MAX_BATCH, s2d_pkg::MAX_STRIDE, 1, 1'b0);
      send_word(1023, 1023, 2047, 15, $urandom);
      send_word(0, 0, 0, 0, $urandom);
      send_word(517, 3, 1000, 7, $urandom);
      drain();
      set_config(s2d_pkg::MAX_DIM, s2d_pkg::MAX_DIM, s2d_pkg::MAX_CHANNELS,
                 s2d_pkg::MAX_BATCH, s2d_pkg::MAX_STRIDE, 0, 1'b1);
      send_word(1023, 1023, 2047, 15, $urandom);
      send_word(1, 2, 63, 0, $urandom);
      drain();

      // smallest legal tensor
      set_config(1, 1, 1, 1, 1, 1, 1'b0);
      send_word(0, 0, 0, 0, $urandom);
      drain();
      // zero stride
      set_config(4, 4, 16, 2, 0, 1, 1'b0);
      send_word(0, 0, 0, 0, $urandom);
      drain();
      // fewer channels than one block holds
      set_config(4, 4, 3, 2, 2, 1, 1'b0);
      send_word(0, 0, 0, 0, $urandom);
      drain();
      // each register past its limit, then a zero width
      set_config(2047, 4, 16, 2, 2, 1, 1'b0);
      send_word(0, 0, 0, 0, $urandom);
      drain();
      set_config(4, 1025, 16, 2, 2, 1, 1'b0);
      send_word(0, 0, 0, 0, $urandom);
      drain();
      set_config(4, 4, 4095, 2, 2, 1, 1'b0);
      send_word(0, 0, 0, 0, $urandom);
      drain();
      set_config(4, 4, 16, 31, 2, 1, 1'b0);
      send_word(0, 0, 0, 0, $urandom);
      drain();
      set_config(4, 4, 16, 2, 15, 1, 1'b0);
      send_word(0, 0, 0, 0, $urandom);
      drain();
      set_config(0, 4, 16, 2, 2, 1, 1'b0);
      send_word(0, 0, 0, 0, $urandom);
      drain();
      // channel count not a multiple of the block area
      set_config(5, 3, 13, 2, 3, 0, 1'b0);
      send_word(4, 2, 12, 1, $urandom);
      send_word(2, 1, 5, 0, $urandom);
      drain();

      while (random_sent < 1700) begin
         random_config();
         send_quiet = ($urandom_range(0, 4) == 0);
         recv_quiet = ($urandom_range(0, 4) == 0);
         burst = $urandom_range(20, 80);
         repeat (burst) begin
            clean = ($urandom_range(0, 99) < 85);
            send_word(pick_coord(addr_board.width_reg, s2d_pkg::COL_BITS, clean),
                      pick_coord(addr_board.height_reg, s2d_pkg::ROW_BITS, clean),
                      pick_coord(addr_board.channels_reg, s2d_pkg::CHAN_BITS, clean),
                      pick_coord(addr_board.batch_reg, s2d_pkg::IMAGE_BITS, clean),
                      $urandom);
         end
         random_sent += burst;
         drain();
      end

      // let any stray rsp word show up
      repeat (16) @(posedge clock);
      if (addr_board.mismatch_count == 0 && addr_board.awaited.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #15_000_000;
      $display("timeout: run did not complete");
      $display("Some tests failed");
      $finish;
   end

endmodule
